FILE: rtl/obr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obr_pkg: shared types and constants for the orbital block rotation.
// Holds widths, register indexes, the sqrt(3) constant and helper functions.
// ----------------------------------------------------------------------------
package obr_pkg;
    localparam int COEF_W   = 24;
    localparam int IDX_W    = 12;
    localparam int ELEM_W   = 18;
    localparam int ROW_W    = 54;
    localparam int CFG_IDX_W = 2;
    localparam int DENT_W   = 29;   // a d entry in Q.24; a sum of two extreme products
                                    // reaches +2^27, so one bit beyond 28 is needed
    localparam logic signed [27:0] SQRT3_Q26 = 28'sd116235962;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

    localparam logic [1:0] SET_EMPTY = 2'd0;
    localparam logic [1:0] SET_S     = 2'd1;
    localparam logic [1:0] SET_SP    = 2'd2;
    localparam logic [1:0] SET_SPD   = 2'd3;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [DENT_W-1:0] dent_t;

    typedef struct packed {
        logic [1:0] shell_set;
        logic [IDX_W-1:0] index;
        coef_t      s;
    } side_t;

    // Saturate a wide signed value to the coefficient range.
    function automatic coef_t sat_coef(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd8388607;
        lo = -64'sd8388608;
        if (v > hi) return coef_t'(hi);
        if (v < lo) return coef_t'(lo);
        return v[COEF_W-1:0];
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int sh);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (sh - 1));
        return t >>> sh;
    endfunction
endpackage

FILE: rtl/obr_dmat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obr_dmat: builds the 5x5 l = 2 matrix from the rotation registers.
// Two register stages: element products, then sqrt(3) scaling and rounding.
// The matrix only moves when the configuration changes.
// ----------------------------------------------------------------------------
module obr_dmat
    import obr_pkg::*;
(
    input  logic                clk,
    input  logic [ROW_W-1:0]    row_x,
    input  logic [ROW_W-1:0]    row_y,
    input  logic [ROW_W-1:0]    row_z,
    output dent_t               dmat [25]
);
    elem_t r00, r0p, r0m, rp0, rpp, rpm, rm0, rmp, rmm;
    assign r00 = row_z[53:36];
    assign r0p = row_z[17:0];
    assign r0m = row_z[35:18];
    assign rp0 = row_x[53:36];
    assign rpp = row_x[17:0];
    assign rpm = row_x[35:18];
    assign rm0 = row_y[53:36];
    assign rmp = row_y[17:0];
    assign rmm = row_y[35:18];

    // Stage one: exact Q.32 sums of element products.
    logic signed [37:0] q_reg [25];
    logic signed [37:0] q_next [25];

    function automatic logic signed [37:0] mp(input elem_t a, input elem_t b);
        return 38'(a) * 38'(b);
    endfunction

    always_comb
    begin
        q_next[0]  = 38'(3) * mp(r00, r00) - (38'sd1 <<< 32);
        q_next[1]  = mp(r00, r0p);
        q_next[2]  = mp(r00, r0m);
        q_next[3]  = mp(r0p, r0p) - mp(r0m, r0m);
        q_next[4]  = mp(r0p, r0m);
        q_next[5]  = mp(rp0, r00);
        q_next[6]  = mp(rpp, r00) + mp(rp0, r0p);
        q_next[7]  = mp(rpm, r00) + mp(rp0, r0m);
        q_next[8]  = mp(rpp, r0p) - mp(rpm, r0m);
        q_next[9]  = mp(rpp, r0m) + mp(r0p, rpm);
        q_next[10] = mp(rm0, r00);
        q_next[11] = mp(rmp, r00) + mp(r0p, rm0);
        q_next[12] = mp(rmm, r00) + mp(r0m, rm0);
        q_next[13] = mp(rmp, r0p) - mp(rmm, r0m);
        q_next[14] = mp(rmp, r0m) + mp(r0p, rmm);
        q_next[15] = mp(rp0, rp0) - mp(rm0, rm0);
        q_next[16] = mp(rpp, rp0) - mp(rmp, rm0);
        q_next[17] = mp(rpm, rp0) - mp(rmm, rm0);
        q_next[18] = mp(rpp, rpp) + mp(rmm, rmm) - mp(rmp, rmp) - mp(rpm, rpm);
        q_next[19] = mp(rpp, rpm) - mp(rmp, rmm);
        q_next[20] = mp(rp0, rm0);
        q_next[21] = mp(rpp, rm0) + mp(rmp, rp0);
        q_next[22] = mp(rpm, rm0) + mp(rmm, rp0);
        q_next[23] = mp(rpp, rmp) - mp(rpm, rmm);
        q_next[24] = mp(rpp, rmm) + mp(rmp, rpm);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // Stage two: round to Q.24, with sqrt(3) where the entry needs it.
    dent_t d_reg [25];
    dent_t d_next [25];

    always_comb
    begin
        for (int k = 0; k < 25; k++)
        begin
            if (k == 1 || k == 2 || k == 4 || k == 5 || k == 10 || k == 20)
                d_next[k] = DENT_W'(rshr(64'(q_reg[k]) * 64'(SQRT3_Q26), 34));
            else if (k == 3 || k == 15)
                d_next[k] = DENT_W'(rshr(64'(q_reg[k]) * 64'(SQRT3_Q26), 35));
            else if (k == 0 || k == 18)
                d_next[k] = DENT_W'(rshr(64'(q_reg[k]), 9));
            else
                d_next[k] = DENT_W'(rshr(64'(q_reg[k]), 8));
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign dmat = d_reg;
endmodule

FILE: rtl/obr_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obr_dot: three-stage pipelined dot product of up to five terms.
// Stage one multiplies, stage two adds, stage three rounds and saturates.
// ----------------------------------------------------------------------------
module obr_dot
    import obr_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  dent_t        m   [5],
    input  coef_t        c   [5],
    input  logic [5:0]   shift,
    output coef_t        y
);
    logic signed [51:0] p_reg [5];
    logic signed [54:0] sum_reg;
    logic [5:0]         sh1_reg, sh2_reg;
    coef_t              y_reg;
    logic signed [54:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < 5; k++)
            sum_next = sum_next + 55'(p_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 5; k++)
            p_reg[k] <= en ? 52'(m[k]) * 52'(c[k]) : '0;
        sh1_reg <= shift;
        sum_reg <= sum_next;
        sh2_reg <= sh1_reg;
        y_reg   <= sat_coef(rshr(64'(sum_reg), int'(sh2_reg)));
    end

    assign y = y_reg;
endmodule

FILE: rtl/orbital_block_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbital_block_rotation: rotates one atom's s/p/d coefficient block.
// Top level with configuration registers, side pipeline and dot lanes.
// ----------------------------------------------------------------------------
// Usage: a beat enters when start is high and busy is low; busy is always low,
// so one block may enter every cycle. Each beat carries the shell set, the
// target index and nine Q7.16 coefficients. A non-empty block gives one
// result beat, marked by done for exactly one cycle; an empty block gives
// nothing. The result passes through the three stages of each dot lane:
// multiply, add, round and saturate. The s
// coefficient and index ride a matching side pipeline. Absent shells read as
// zero. The receiver cannot stall, so results are never held.
// Configuration: cfg_we writes rotation row cfg_index (x, y, z as 0, 1, 2);
// the derived d matrix settles through its product and rounding registers
// after a write, so writes must be made while the block is idle. Reset
// restores the identity rotation and clears the valid bits; d then refills.
// ----------------------------------------------------------------------------
module orbital_block_rotation
    import obr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    input  logic [1:0]           shell_set,
    input  logic [IDX_W-1:0]     target_first_index,
    input  coef_t                coef_s,
    input  coef_t                coef_pz,
    input  coef_t                coef_px,
    input  coef_t                coef_py,
    input  coef_t                coef_d0,
    input  coef_t                coef_d1,
    input  coef_t                coef_d2,
    input  coef_t                coef_d3,
    input  coef_t                coef_d4,
    output logic                 done,
    output logic [IDX_W-1:0]     dest_first_index,
    output logic [1:0]           out_shell_set,
    output coef_t                rot_s,
    output coef_t                rot_pz,
    output coef_t                rot_px,
    output coef_t                rot_py,
    output coef_t                rot_d0,
    output coef_t                rot_d1,
    output coef_t                rot_d2,
    output coef_t                rot_d3,
    output coef_t                rot_d4
);
    logic [ROW_W-1:0] row_x_reg, row_y_reg, row_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= ROW_W'(65536);
            row_y_reg <= ROW_W'(65536) << 18;
            row_z_reg <= ROW_W'(65536) << 36;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_X: row_x_reg <= cfg_data;
                REG_ROW_Y: row_y_reg <= cfg_data;
                REG_ROW_Z: row_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    dent_t dmat [25];
    obr_dmat u_dmat (
        .clk   (clk),
        .row_x (row_x_reg),
        .row_y (row_y_reg),
        .row_z (row_z_reg),
        .dmat  (dmat)
    );

    // The p matrix in Q.16, widened so it shares the dot lanes.
    dent_t pm [9];
    assign pm[0] = DENT_W'($signed(row_z_reg[53:36]));
    assign pm[1] = DENT_W'($signed(row_z_reg[17:0]));
    assign pm[2] = DENT_W'($signed(row_z_reg[35:18]));
    assign pm[3] = DENT_W'($signed(row_x_reg[53:36]));
    assign pm[4] = DENT_W'($signed(row_x_reg[17:0]));
    assign pm[5] = DENT_W'($signed(row_x_reg[35:18]));
    assign pm[6] = DENT_W'($signed(row_y_reg[53:36]));
    assign pm[7] = DENT_W'($signed(row_y_reg[17:0]));
    assign pm[8] = DENT_W'($signed(row_y_reg[35:18]));

    logic  accept;
    logic  has_p, has_d;
    coef_t cp [5];
    coef_t cd [5];
    coef_t lane_y [8];

    assign accept = start && !busy && (shell_set != SET_EMPTY);
    assign has_p  = (shell_set == SET_SP) || (shell_set == SET_SPD);
    assign has_d  = (shell_set == SET_SPD);

    assign cp[0] = coef_pz;
    assign cp[1] = coef_px;
    assign cp[2] = coef_py;
    assign cp[3] = '0;
    assign cp[4] = '0;
    assign cd[0] = coef_d0;
    assign cd[1] = coef_d1;
    assign cd[2] = coef_d2;
    assign cd[3] = coef_d3;
    assign cd[4] = coef_d4;

    // Three p lanes, then five d lanes.
    for (genvar i = 0; i < 8; i++)
    begin : g_lane
        dent_t mrow [5];
        coef_t crow [5];
        for (genvar j = 0; j < 5; j++)
        begin : g_col
            if (i < 3)
            begin : g_p
                assign mrow[j] = (j < 3) ? pm[i*3 + ((j < 3) ? j : 0)] : '0;
                assign crow[j] = cp[j];
            end
            else
            begin : g_d
                assign mrow[j] = dmat[(i-3)*5 + j];
                assign crow[j] = cd[j];
            end
        end
        obr_dot u_dot (
            .clk   (clk),
            .en    ((i < 3) ? has_p : has_d),
            .m     (mrow),
            .c     (crow),
            .shift ((i < 3) ? 6'd16 : 6'd24),
            .y     (lane_y[i])
        );
    end

    // Valid bits travel beside the side data, which needs no reset.
    logic [2:0] valid_reg;
    side_t side_reg [3];
    side_t side_next;

    assign side_next = '{shell_set: shell_set, index: target_first_index, s: coef_s};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], accept};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        side_reg[1] <= side_reg[0];
        side_reg[2] <= side_reg[1];
    end

    assign done             = valid_reg[2];
    assign dest_first_index = side_reg[2].index;
    assign out_shell_set    = side_reg[2].shell_set;
    assign rot_s            = side_reg[2].s;
    assign rot_pz           = lane_y[0];
    assign rot_px           = lane_y[1];
    assign rot_py           = lane_y[2];
    assign rot_d0           = lane_y[3];
    assign rot_d1           = lane_y[4];
    assign rot_d2           = lane_y[5];
    assign rot_d3           = lane_y[6];
    assign rot_d4           = lane_y[7];

`ifndef SYNTHESIS
    a_done_lat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result beat missing");
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_shell_set != SET_EMPTY)
        else $error("empty block produced a result");
    a_p_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_shell_set == SET_S) |-> (rot_pz == '0 && rot_px == '0))
        else $error("absent p shell not zero");
    a_d_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_shell_set != SET_SPD) |-> (rot_d0 == '0 && rot_d4 == '0))
        else $error("absent d shell not zero");
`endif
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for orbital_block_rotation.
// Directed blocks under the reset rotation are checked against typed-in
// values. Randomized blocks under several rotation settings, the extreme
// ones among them, are checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
    import obr_pkg::*;

    // Index outside the register file; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint SQRT3_FIX = 116235962;   // sqrt(3) in Q.26
    localparam int     PHASES    = 9;
    localparam int     PER_PHASE = 145;

    // One atom block as it enters the block.
    typedef struct packed {
        logic [1:0]        set;
        logic [IDX_W-1:0]  idx;
        logic [8:0][23:0]  c;      // s, pz, px, py, d0..d4
    } atom_blk_t;

    // One rotated block as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [1:0]        set;
        logic [8:0][23:0]  c;
    } rot_blk_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic [1:0] shell_set = '0;
    logic [IDX_W-1:0] target_first_index = '0;
    coef_t coef_s = '0, coef_pz = '0, coef_px = '0, coef_py = '0;
    coef_t coef_d0 = '0, coef_d1 = '0, coef_d2 = '0, coef_d3 = '0, coef_d4 = '0;
    logic done;
    logic [IDX_W-1:0] dest_first_index;
    logic [1:0] out_shell_set;
    coef_t rot_s, rot_pz, rot_px, rot_py, rot_d0, rot_d1, rot_d2, rot_d3, rot_d4;

    orbital_block_rotation dut (.*);

    always #2 clk = ~clk;

    // The bench's own copy of the three rotation rows.
    logic [ROW_W-1:0] rot_rows [3];
    rot_blk_t pending_rot [$];
    int errors = 0;
    int sent = 0;
    int idle_pct = 31;

    // Round half up to a coarser precision (arithmetic shift floors).
    function automatic longint round_up(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint sqrt3_term(longint p, int sh);
        return round_up(p * SQRT3_FIX, sh);
    endfunction

    function automatic logic [23:0] clip(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    function automatic longint rot_elem(int r, int col);
        logic signed [17:0] e;
        e = rot_rows[r][18*col +: 18];
        return longint'(e);
    endfunction

    // Rotate one block with the current rows. Empty blocks give no result.
    function automatic bit rotate_block(input atom_blk_t b, output rot_blk_t r);
        longint cf [9];
        longint pm [3][3];
        longint dm [5][5];
        longint acc;
        longint a00, a0p, a0m, ap0, app, apm, am0, amp, amm;
        r = '0;
        if (b.set == SET_EMPTY) return 1'b0;
        for (int k = 0; k < 9; k++) cf[k] = longint'($signed(b.c[k]));
        r.idx = b.idx;
        r.set = b.set;
        r.c[0] = b.c[0];
        if (b.set == SET_S) return 1'b1;
        a00 = rot_elem(2, 2); a0p = rot_elem(2, 0); a0m = rot_elem(2, 1);
        ap0 = rot_elem(0, 2); app = rot_elem(0, 0); apm = rot_elem(0, 1);
        am0 = rot_elem(1, 2); amp = rot_elem(1, 0); amm = rot_elem(1, 1);
        pm = '{'{a00, a0p, a0m}, '{ap0, app, apm}, '{am0, amp, amm}};
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += pm[i][j] * cf[1 + j];
            r.c[1 + i] = clip(round_up(acc, 16));
        end
        if (b.set != SET_SPD) return 1'b1;
        // Entries of the l = 2 rotation in Q.24.
        dm[0][0] = round_up(3 * a00 * a00 - (longint'(1) << 32), 9);
        dm[0][1] = sqrt3_term(a00 * a0p, 34);
        dm[0][2] = sqrt3_term(a00 * a0m, 34);
        dm[0][3] = sqrt3_term(a0p * a0p - a0m * a0m, 35);
        dm[0][4] = sqrt3_term(a0p * a0m, 34);
        dm[1][0] = sqrt3_term(ap0 * a00, 34);
        dm[1][1] = round_up(app * a00 + ap0 * a0p, 8);
        dm[1][2] = round_up(apm * a00 + ap0 * a0m, 8);
        dm[1][3] = round_up(app * a0p - apm * a0m, 8);
        dm[1][4] = round_up(app * a0m + a0p * apm, 8);
        dm[2][0] = sqrt3_term(am0 * a00, 34);
        dm[2][1] = round_up(amp * a00 + a0p * am0, 8);
        dm[2][2] = round_up(amm * a00 + a0m * am0, 8);
        dm[2][3] = round_up(amp * a0p - amm * a0m, 8);
        dm[2][4] = round_up(amp * a0m + a0p * amm, 8);
        dm[3][0] = sqrt3_term(ap0 * ap0 - am0 * am0, 35);
        dm[3][1] = round_up(app * ap0 - amp * am0, 8);
        dm[3][2] = round_up(apm * ap0 - amm * am0, 8);
        dm[3][3] = round_up(app * app + amm * amm - amp * amp - apm * apm, 9);
        dm[3][4] = round_up(app * apm - amp * amm, 8);
        dm[4][0] = sqrt3_term(ap0 * am0, 34);
        dm[4][1] = round_up(app * am0 + amp * ap0, 8);
        dm[4][2] = round_up(apm * am0 + amm * ap0, 8);
        dm[4][3] = round_up(app * amp - apm * amm, 8);
        dm[4][4] = round_up(app * amm + amp * apm, 8);
        for (int i = 0; i < 5; i++)
        begin
            acc = 0;
            for (int j = 0; j < 5; j++) acc += dm[i][j] * cf[4 + j];
            r.c[4 + i] = clip(round_up(acc, 24));
        end
        return 1'b1;
    endfunction

    // Present one block and hold it until the block takes it. Busy only
    // moves on a rising edge, so its value at the falling edge is the one
    // the next rising edge sees.
    task automatic send_block(input atom_blk_t b, input bit typed);
        logic was_busy;
        rot_blk_t exp_rot;
        rot_blk_t typed_rot;
        bit gives;
        start <= 1'b1;
        shell_set <= b.set;
        target_first_index <= b.idx;
        {coef_d4, coef_d3, coef_d2, coef_d1, coef_d0,
         coef_py, coef_px, coef_pz, coef_s} <= b.c;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        gives = rotate_block(b, exp_rot);
        if (typed && gives)
        begin
            // Under the reset rotation the block is passed through, with
            // absent shells reading as zero.
            typed_rot = '{idx: b.idx, set: b.set, c: b.c};
            if (b.set == SET_S) typed_rot.c[8:1] = '0;
            if (b.set == SET_SP) typed_rot.c[8:4] = '0;
            if (typed_rot != exp_rot)
            begin
                $error("predictor disagrees with the typed-in result");
                errors++;
            end
            exp_rot = typed_rot;
        end
        if (gives) pending_rot.push_back(exp_rot);
        if (b.set != SET_EMPTY) sent++;
        // Sender gap: start drops for a few cycles, or stays high.
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Wait until every beat has come back, then let the pipeline drain past
    // any empty block still inside it.
    task automatic drain_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rot.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Writes one row; the caller drops cfg_we after its last write.
    task automatic write_row(input logic [CFG_IDX_W-1:0] ri, input logic [ROW_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge clk);
        if (ri != REG_UNUSED) rot_rows[ri] = v;
    endtask

    function automatic logic [ROW_W-1:0] pack_row(logic [17:0] a, logic [17:0] b,
                                                 logic [17:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [17:0] pick_elem();
        case ($urandom_range(5))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2, 3: return 18'($signed($urandom_range(0, 131072)) - 65536);
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_coef();
        case ($urandom_range(7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2, 3, 4: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic atom_blk_t pick_block();
        atom_blk_t b;
        // Mostly full s, p and d blocks; a few empty ones as noise.
        case ($urandom_range(19))
            0: b.set = SET_EMPTY;
            1, 2, 3: b.set = SET_S;
            4, 5, 6, 7: b.set = SET_SP;
            default: b.set = SET_SPD;
        endcase
        b.idx = 12'($urandom);
        for (int k = 0; k < 9; k++) b.c[k] = pick_coef();
        return b;
    endfunction

    // Directed blocks, all under the reset rotation.
    localparam atom_blk_t DIRECTED [14] = '{
        '{SET_EMPTY, 12'd5,    {9{24'h123456}}},
        '{SET_S,     12'd0,    {9{24'h7fffff}}},
        '{SET_S,     12'd4095, {9{24'h800000}}},
        '{SET_SP,    12'd1,    {9{24'h7fffff}}},
        '{SET_SP,    12'd4094, {9{24'h800000}}},
        '{SET_SPD,   12'd0,    {9{24'h7fffff}}},
        '{SET_SPD,   12'd4095, {9{24'h800000}}},
        '{SET_SPD,   12'haaa,  {9{24'haaaaaa}}},
        '{SET_SPD,   12'h555,  {9{24'h555555}}},
        '{SET_SPD,   12'd17,   {9{24'h000000}}},
        '{SET_SPD,   12'd18,   {9{24'hffffff}}},
        '{SET_EMPTY, 12'd4095, {9{24'h7fffff}}},
        '{SET_SP,    12'd300,  {24'h1, 24'h2, 24'h3, 24'h4, 24'h5,
                                24'hfffffe, 24'h10000, 24'hff0000, 24'h7}},
        '{SET_SPD,   12'd301,  {24'h7fffff, 24'h800000, 24'h10000, 24'hff0000,
                                24'h1, 24'hffffff, 24'h2, 24'h3, 24'h4}}
    };

    // Results: each done beat is compared with the oldest expectation.
    always @(negedge clk)
    begin
        rot_blk_t seen;
        rot_blk_t want;
        if (rst_n && done)
        begin
            seen = '{idx: dest_first_index, set: out_shell_set,
                     c: {rot_d4, rot_d3, rot_d2, rot_d1, rot_d0,
                         rot_py, rot_px, rot_pz, rot_s}};
            if (pending_rot.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_rot.pop_front();
                if (seen.idx != want.idx)
                begin
                    $error("dest_first_index: expected %0d, got %0d", want.idx, seen.idx);
                    errors++;
                end
                if (seen.set != want.set)
                begin
                    $error("out_shell_set: expected %0d, got %0d", want.set, seen.set);
                    errors++;
                end
                for (int k = 0; k < 9; k++)
                begin
                    if (seen.c[k] != want.c[k])
                    begin
                        $error("%s: expected %0d, got %0d",
                               k == 0 ? "rot_s" : k == 1 ? "rot_pz" : k == 2 ? "rot_px" :
                               k == 3 ? "rot_py" : k == 4 ? "rot_d0" : k == 5 ? "rot_d1" :
                               k == 6 ? "rot_d2" : k == 7 ? "rot_d3" : "rot_d4",
                               $signed(want.c[k]), $signed(seen.c[k]));
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [17:0] e0, e1, e2;
        rot_rows[0] = pack_row(18'h10000, 18'h0, 18'h0);
        rot_rows[1] = pack_row(18'h0, 18'h10000, 18'h0);
        rot_rows[2] = pack_row(18'h0, 18'h0, 18'h10000);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        foreach (DIRECTED[i]) send_block(DIRECTED[i], 1'b1);
        drain_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Rotation setting for this phase: extremes first, then random.
            for (int r = 0; r < 3; r++)
            begin
                case (ph)
                    0: begin e0 = 18'h1ffff; e1 = 18'h1ffff; e2 = 18'h1ffff; end
                    1: begin e0 = 18'h20000; e1 = 18'h20000; e2 = 18'h20000; end
                    2: begin e0 = 18'h0; e1 = 18'h0; e2 = 18'h0; end
                    3:
                    begin
                        // Negated identity.
                        e0 = (r == 0) ? 18'h30000 : 18'h0;
                        e1 = (r == 1) ? 18'h30000 : 18'h0;
                        e2 = (r == 2) ? 18'h30000 : 18'h0;
                    end
                    default: begin e0 = pick_elem(); e1 = pick_elem(); e2 = pick_elem(); end
                endcase
                write_row(r == 0 ? REG_ROW_X : r == 1 ? REG_ROW_Y : REG_ROW_Z,
                          pack_row(e0, e1, e2));
            end
            if (ph == 5) write_row(REG_UNUSED, {ROW_W{1'b1}});
            cfg_we <= 1'b0;
            // Let the derived d matrix settle before the first beat.
            repeat (4) @(posedge clk);

            for (int n = 0; n < PER_PHASE; n++)
            begin
                idle_pct = (sent < 450) ? 31 : (sent < 900) ? 54 : 0;
                send_block(pick_block(), 1'b0);
                if (ph == 6 && n == PER_PHASE / 2)
                begin
                    // Sender holds off until the pipeline is empty.
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending_rot.size() != 0) @(posedge clk);
                end
            end
            drain_idle();
        end

        if (pending_rot.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_rot.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
rtl/obr_pkg.sv
rtl/obr_dmat.sv
rtl/obr_dot.sv
rtl/orbital_block_rotation.sv
sim/testbench.sv
